// ----- design/bhs_pkg.sv -----
package bhs_pkg;

    // header and tag codes
    localparam logic [31:0] HDR_MAGIC    = 32'hE852_50D6;
    localparam logic [15:0] KIND_ADDRESS = 16'd2;
    localparam logic [15:0] KIND_ENTRY   = 16'd3;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_ZERO_TAG  = 2'd3;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // saturation point of the walk offset
    localparam logic [32:0] POS_MAX = 33'h1_FFFF_FFFF;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_WALK,
        PH_DONE
    } t_phase;

    // one classified image word as it travels from front to back
    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic        hit;
        logic        exhaust;
        logic [14:0] offset;
        logic [31:0] hdr_len;
    } t_scan_beat;

endpackage

// ----- design/bhs_front.sv -----
module bhs_front
    import bhs_pkg::*;
#(
    parameter int SEARCH_WORDS = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_image_word,
    input  logic        i_final_word,
    input  logic        i_full,
    output logic        o_push,
    output t_scan_beat  o_beat
);

    localparam int CW = $clog2(SEARCH_WORDS + 4);
    localparam logic [CW-1:0] CNT_MAX  = CW'(SEARCH_WORDS + 3);
    localparam logic [CW-1:0] CNT_EXH  = CW'(SEARCH_WORDS + 2);
    localparam logic [CW-1:0] CNT_BASE = CW'(3);

    logic [31:0]   r_win0, r_win1, r_win2;
    logic [CW-1:0] r_count;
    logic [CW-1:0] start_idx;
    logic [31:0]   start_wide;
    logic [31:0]   sum4;
    logic          accept;
    logic          have_window;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;
    assign o_push     = accept;

    // header test against the last three words and the new one
    assign have_window = (r_count >= CNT_BASE);
    assign start_idx   = r_count - CNT_BASE;
    assign start_wide  = 32'(start_idx);
    assign sum4        = r_win0 + r_win1 + r_win2 + i_image_word;

    always_comb begin
        o_beat.word    = i_image_word;
        o_beat.last    = i_final_word;
        o_beat.hit     = have_window && (r_count < CNT_MAX) && (r_win0 == HDR_MAGIC)
                         && (sum4 == 32'd0);
        o_beat.exhaust = have_window && (r_count >= CNT_EXH);
        o_beat.offset  = 15'(start_wide << 2);
        o_beat.hdr_len = r_win2;
    end

    // word window and position, restarted after each image
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win0  <= '0;
            r_win1  <= '0;
            r_win2  <= '0;
            r_count <= '0;
        end else if (accept) begin
            if (i_final_word) begin
                r_win0  <= '0;
                r_win1  <= '0;
                r_win2  <= '0;
                r_count <= '0;
            end else begin
                r_win0 <= r_win1;
                r_win1 <= r_win2;
                r_win2 <= i_image_word;
                if (r_count != CNT_MAX) begin
                    r_count <= r_count + CW'(1);
                end
            end
        end
    end

endmodule

// ----- design/bhs_queue.sv -----
module bhs_queue
    import bhs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_scan_beat i_beat,
    output logic       o_full,
    output logic       o_valid,
    output t_scan_beat o_beat,
    input  logic       i_pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_scan_beat  r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_fill;

    assign o_full  = (r_fill == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_beat  = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_beat;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + (PW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - (PW+1)'(1);
            end
        end
    end

endmodule

// ----- design/bhs_back.sv -----
module bhs_back
    import bhs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_scan_beat  i_beat,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [14:0] o_header_offset,
    output logic [31:0] o_header_address,
    output logic [31:0] o_load_address,
    output logic [31:0] o_load_end_address,
    output logic [31:0] o_bss_end_address,
    output logic [31:0] o_entry_address
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_hlen, n_hlen;
    logic [32:0] r_walk, n_walk;
    logic [32:0] r_tag_start, n_tag_start;
    logic [32:0] r_tag_end, n_tag_end;
    logic [15:0] r_tag_kind, n_tag_kind;
    logic [14:0] r_found, n_found;
    logic [31:0] r_cap [5];
    logic [31:0] n_cap [5];
    logic [1:0]  r_held, n_held;

    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_out_status, n_out_status;
    logic [14:0] r_out_offset, n_out_offset;
    logic [31:0] r_out_cap [5];
    logic [31:0] n_out_cap [5];

    logic [33:0] pos, ts, te, te_v, nxt, lim, pos4, fidx;
    logic [15:0] kind_v;
    logic        at_kind, at_size, in_body;
    logic [1:0]  final_st;

    // a final word needs a free result slot
    assign o_pop = i_valid && (!i_beat.last || !r_out_valid || i_out_ready);

    // walk datapath
    always_comb begin
        pos     = {1'b0, r_walk};
        ts      = {1'b0, r_tag_start};
        te      = {1'b0, r_tag_end};
        pos4    = pos + 34'd4;
        at_kind = (pos == ts);
        at_size = (pos == ts + 34'd4);
        in_body = (pos >= ts + 34'd8) && (pos4 <= te);
        fidx    = pos - ts - 34'd8;
        kind_v  = at_kind ? i_beat.word[15:0] : r_tag_kind;
        te_v    = at_size ? (ts + {2'b00, i_beat.word}) : te;
        nxt     = (te_v + 34'd7) & ~34'd7;
        if (kind_v == KIND_ADDRESS) begin
            lim = ts + 34'd24;
        end else if (kind_v == KIND_ENTRY) begin
            lim = ts + 34'd12;
        end else begin
            lim = ts + 34'd8;
        end
    end

    // next state of the scan and the result slot
    always_comb begin
        n_phase     = r_phase;
        n_hlen      = r_hlen;
        n_walk      = r_walk;
        n_tag_start = r_tag_start;
        n_tag_end   = r_tag_end;
        n_tag_kind  = r_tag_kind;
        n_found     = r_found;
        n_cap       = r_cap;
        n_held      = r_held;
        final_st    = ST_OK;

        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_offset = r_out_offset;
        n_out_cap    = r_out_cap;

        if (o_pop) begin
            case (r_phase)
                PH_SEARCH: begin
                    if (i_beat.hit) begin
                        n_found = i_beat.offset;
                        n_hlen  = i_beat.hdr_len;
                        if (i_beat.hdr_len <= 32'd16) begin
                            n_phase = PH_DONE;
                            n_held  = ST_OK;
                        end else begin
                            n_phase     = PH_WALK;
                            n_tag_start = 33'd16;
                            n_walk      = 33'd16;
                        end
                    end else if (i_beat.exhaust) begin
                        n_phase = PH_DONE;
                        n_held  = ST_NOT_FOUND;
                    end
                end
                PH_WALK: begin
                    n_tag_kind = kind_v;
                    if (at_size && (i_beat.word == 32'd0)) begin
                        n_phase = PH_DONE;
                        n_held  = ST_ZERO_TAG;
                    end else begin
                        n_tag_end = te_v[32:0];
                        // field capture inside the tag body
                        if (in_body) begin
                            if (kind_v == KIND_ADDRESS && fidx < 34'd16) begin
                                n_cap[fidx[3:2]] = i_beat.word;
                            end else if (kind_v == KIND_ENTRY && fidx < 34'd4) begin
                                n_cap[4] = i_beat.word;
                            end
                        end
                        // step to the next tag or finish
                        if (pos >= ts + 34'd4) begin
                            if (pos4 >= nxt) begin
                                if (nxt >= {2'b00, r_hlen}) begin
                                    n_phase = PH_DONE;
                                    n_held  = ST_OK;
                                end else begin
                                    n_tag_start = nxt[32:0];
                                end
                            end else if (pos4 >= lim && nxt >= {2'b00, r_hlen}) begin
                                n_phase = PH_DONE;
                                n_held  = ST_OK;
                            end
                        end
                        n_walk = (pos4 > {1'b0, POS_MAX}) ? POS_MAX : pos4[32:0];
                    end
                end
                default: begin
                end
            endcase

            // final word: deliver the result and restart
            if (i_beat.last) begin
                case (n_phase)
                    PH_SEARCH: final_st = ST_NOT_FOUND;
                    PH_WALK:   final_st = ST_TRUNCATED;
                    default:   final_st = n_held;
                endcase
                n_out_valid  = 1'b1;
                n_out_status = final_st;
                n_out_offset = (final_st == ST_NOT_FOUND) ? 15'd0 : n_found;
                n_out_cap    = n_cap;

                n_phase     = PH_SEARCH;
                n_hlen      = '0;
                n_walk      = '0;
                n_tag_start = '0;
                n_tag_end   = '0;
                n_tag_kind  = '0;
                n_found     = '0;
                n_held      = ST_OK;
                for (int i = 0; i < 5; i++) begin
                    n_cap[i] = '0;
                end
            end
        end
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SEARCH;
            r_hlen      <= '0;
            r_walk      <= '0;
            r_tag_start <= '0;
            r_tag_end   <= '0;
            r_tag_kind  <= '0;
            r_found     <= '0;
            r_held      <= ST_OK;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 5; i++) begin
                r_cap[i] <= '0;
            end
        end else begin
            r_phase     <= n_phase;
            r_hlen      <= n_hlen;
            r_walk      <= n_walk;
            r_tag_start <= n_tag_start;
            r_tag_end   <= n_tag_end;
            r_tag_kind  <= n_tag_kind;
            r_found     <= n_found;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
            r_cap       <= n_cap;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_offset <= n_out_offset;
        r_out_cap    <= n_out_cap;
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_header_offset    = r_out_offset;
    assign o_header_address   = r_out_cap[0];
    assign o_load_address     = r_out_cap[1];
    assign o_load_end_address = r_out_cap[2];
    assign o_bss_end_address  = r_out_cap[3];
    assign o_entry_address    = r_out_cap[4];

endmodule

// ----- design/boot_header_scan_and_tag_extract_core.sv -----
// Boot header scanner and tag extractor.
// Input channel: one 32-bit little-endian image word per beat on i_image_word,
// with i_final_word high on the last beat of an image (i_in_valid / o_in_ready).
// Output channel: one result per image (o_out_valid / i_out_ready) carrying the
// status, the header byte offset and the addresses from the last address tag
// and the last entry tag.
// Throughput: one word per cycle, sustained while the queue is not full.
// The front stage tests each word against a sliding three-word window for the
// header; a four-entry queue decouples it from the back stage, which walks the
// tags at one word a cycle unless a final word waits for a free result slot.
// The result is registered: it shows on the output in the cycle after the back
// stage takes the final word; an accepted beat is first written into the queue.
// A stalled output holds its result; the back stage then halts only at the next
// final word and the queue fills, after which o_in_ready drops.
// Reset clears the window, the queue and the scan state; o_in_ready is high in
// the first cycle after reset. State also restarts after every final word.
module boot_header_scan_and_tag_extract_core
    import bhs_pkg::*;
#(
    parameter int SEARCH_WORDS = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_image_word,
    input  logic        i_final_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [14:0] o_header_offset,
    output logic [31:0] o_header_address,
    output logic [31:0] o_load_address,
    output logic [31:0] o_load_end_address,
    output logic [31:0] o_bss_end_address,
    output logic [31:0] o_entry_address
);

    logic       push, full, q_valid, pop;
    t_scan_beat push_beat, head_beat;

    // classify words
    bhs_front #(
        .SEARCH_WORDS(SEARCH_WORDS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_image_word(i_image_word),
        .i_final_word(i_final_word),
        .i_full      (full),
        .o_push      (push),
        .o_beat      (push_beat)
    );

    // decoupling queue
    bhs_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_beat (push_beat),
        .o_full (full),
        .o_valid(q_valid),
        .o_beat (head_beat),
        .i_pop  (pop)
    );

    // tag walk and result
    bhs_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (q_valid),
        .i_beat            (head_beat),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_header_offset   (o_header_offset),
        .o_header_address  (o_header_address),
        .o_load_address    (o_load_address),
        .o_load_end_address(o_load_end_address),
        .o_bss_end_address (o_bss_end_address),
        .o_entry_address   (o_entry_address)
    );

endmodule

// ----- design/bhs_checker.sv -----
module bhs_checker
    import bhs_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [14:0] o_header_offset,
    input logic [31:0] o_header_address,
    input logic [31:0] o_load_address,
    input logic [31:0] o_load_end_address,
    input logic [31:0] o_bss_end_address,
    input logic [31:0] o_entry_address
);

    // reset empties the result slot and the queue
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("result or back-pressure present right after reset");

    // a missing header reports no offset
    a_not_found_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_NOT_FOUND |-> o_header_offset == 15'd0)
        else $error("header offset reported without a header");

    // a missing header means no tag was walked
    a_not_found_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_NOT_FOUND |->
            o_header_address == 32'd0 && o_load_address == 32'd0 &&
            o_load_end_address == 32'd0 && o_bss_end_address == 32'd0 &&
            o_entry_address == 32'd0)
        else $error("tag fields captured without a header");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) &&
            $stable(o_header_offset) && $stable(o_entry_address))
        else $error("result changed while stalled");

endmodule

bind boot_header_scan_and_tag_extract_core bhs_checker u_bhs_checker (.*);

// ----- dv/tb_boot_header_scan_and_tag_extract_core.sv -----
`timescale 1ns / 100ps

module tb_boot_header_scan_and_tag_extract_core
    import bhs_pkg::*;
();

    localparam int SCAN_WORDS   = 8192;
    localparam int PLAIN_WORDS  = 600;
    localparam int MIN_IMAGES   = 48;
    localparam int CALM_TAIL    = 64;
    localparam int STUCK_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [31:0] word;
        logic        fin;
    } t_image_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] offset;
        logic [31:0] hdr_addr;
        logic [31:0] ld_start;
        logic [31:0] load_end;
        logic [31:0] bss_end;
        logic [31:0] entry;
    } t_boot_info;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_image_word = '0;
    logic        i_final_word = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [14:0] o_header_offset;
    logic [31:0] o_header_address;
    logic [31:0] o_load_address;
    logic [31:0] o_load_end_address;
    logic [31:0] o_bss_end_address;
    logic [31:0] o_entry_address;

    t_image_beat pending_beats[$];
    t_boot_info  expected_boot_info[$];
    logic [31:0] image_buf[$];
    logic [31:0] tag_buf[$];

    int mismatch_count = 0;
    int results_seen = 0;
    int stuck_cycles = 0;

    // scan tracker state
    logic [31:0]     win_q [3];
    int unsigned     words_seen;
    t_phase          scan_phase;
    logic [31:0]     hdr_len;
    longint unsigned walk_pos;
    longint unsigned tag_base;
    longint unsigned tag_limit;
    logic [15:0]     tag_code;
    logic [14:0]     hdr_off;
    logic [31:0]     caught [5];
    logic [1:0]      done_status;

    boot_header_scan_and_tag_extract_core #(
        .SEARCH_WORDS(SCAN_WORDS)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_image_word      (i_image_word),
        .i_final_word      (i_final_word),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_header_offset   (o_header_offset),
        .o_header_address  (o_header_address),
        .o_load_address    (o_load_address),
        .o_load_end_address(o_load_end_address),
        .o_bss_end_address (o_bss_end_address),
        .o_entry_address   (o_entry_address)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // scan tracker
    // ------------------------------------------------------------------

    task automatic clear_scan();
        foreach (win_q[i]) win_q[i] = '0;
        foreach (caught[i]) caught[i] = '0;
        words_seen  = 0;
        scan_phase  = PH_SEARCH;
        hdr_len     = '0;
        walk_pos    = 0;
        tag_base    = 0;
        tag_limit   = 0;
        tag_code    = '0;
        hdr_off     = '0;
        done_status = ST_OK;
    endtask

    task automatic close_scan(input logic [1:0] st);
        scan_phase  = PH_DONE;
        done_status = st;
    endtask

    task automatic search_step(input logic [31:0] w);
        int unsigned pos;
        logic [31:0] total;
        if (words_seen >= 3) begin
            pos   = words_seen - 3;
            total = win_q[0] + win_q[1] + win_q[2] + w;
            // header match: magic in the oldest word and a zero sum
            if (pos < SCAN_WORDS && win_q[0] == HDR_MAGIC && total == 32'd0) begin
                hdr_off = 15'(pos << 2);
                hdr_len = win_q[2];
                if (hdr_len <= 32'd16) begin
                    close_scan(ST_OK);
                end else begin
                    scan_phase = PH_WALK;
                    tag_base   = 16;
                    walk_pos   = 16;
                end
                return;
            end
            if (pos + 1 >= SCAN_WORDS) begin
                close_scan(ST_NOT_FOUND);
                return;
            end
        end
        win_q[0] = win_q[1];
        win_q[1] = win_q[2];
        win_q[2] = w;
        if (words_seen < 32'h7FFF_FFFF) words_seen++;
    endtask

    task automatic walk_step(input logic [31:0] w);
        longint unsigned pos;
        longint unsigned next_tag;
        longint unsigned field_end;
        longint unsigned idx;
        pos = walk_pos;
        // tag type, tag size, then payload fields inside the tag's extent
        if (pos == tag_base) begin
            tag_code = w[15:0];
        end else if (pos == tag_base + 4) begin
            if (w == 32'd0) begin
                close_scan(ST_ZERO_TAG);
                return;
            end
            tag_limit = tag_base + w;
        end else if (pos >= tag_base + 8 && pos + 4 <= tag_limit) begin
            idx = (pos - tag_base - 8) >> 2;
            if (tag_code == KIND_ADDRESS && idx < 4) caught[idx] = w;
            else if (tag_code == KIND_ENTRY && idx == 0) caught[4] = w;
        end
        // advance to the next aligned tag or stop at the header length
        if (pos >= tag_base + 4) begin
            next_tag  = (tag_limit + 7) & ~64'd7;
            field_end = tag_base + (tag_code == KIND_ADDRESS ? 24 :
                                    tag_code == KIND_ENTRY ? 12 : 8);
            if (pos + 4 >= next_tag) begin
                if (next_tag >= hdr_len) begin
                    close_scan(ST_OK);
                    return;
                end
                tag_base = next_tag;
            end else if (pos + 4 >= field_end && next_tag >= hdr_len) begin
                close_scan(ST_OK);
                return;
            end
        end
        walk_pos = (pos + 4 > POS_MAX) ? POS_MAX : pos + 4;
    endtask

    task automatic track_image_word(input logic [31:0] w, input logic fin);
        t_boot_info info;
        if (scan_phase == PH_SEARCH) search_step(w);
        else if (scan_phase == PH_WALK) walk_step(w);
        if (fin) begin
            info.status    = (scan_phase == PH_SEARCH) ? ST_NOT_FOUND :
                             (scan_phase == PH_WALK) ? ST_TRUNCATED : done_status;
            info.offset    = (info.status == ST_NOT_FOUND) ? 15'd0 : hdr_off;
            info.hdr_addr  = caught[0];
            info.ld_start  = caught[1];
            info.load_end  = caught[2];
            info.bss_end   = caught[3];
            info.entry     = caught[4];
            expected_boot_info.push_back(info);
            clear_scan();
        end
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("result %0d: %s got %h want %h", results_seen, what, got, want);
    endtask

    task automatic check_boot_info();
        t_boot_info want;
        if (expected_boot_info.size() == 0) begin
            report_mismatch("unexpected result, status", o_status, '0);
            return;
        end
        want = expected_boot_info.pop_front();
        if (o_status !== want.status)
            report_mismatch("status", o_status, want.status);
        if (o_header_offset !== want.offset)
            report_mismatch("header_offset", o_header_offset, want.offset);
        if (o_header_address !== want.hdr_addr)
            report_mismatch("header_address", o_header_address, want.hdr_addr);
        if (o_load_address !== want.ld_start)
            report_mismatch("load_address", o_load_address, want.ld_start);
        if (o_load_end_address !== want.load_end)
            report_mismatch("load_end_address", o_load_end_address, want.load_end);
        if (o_bss_end_address !== want.bss_end)
            report_mismatch("bss_end_address", o_bss_end_address, want.bss_end);
        if (o_entry_address !== want.entry)
            report_mismatch("entry_address", o_entry_address, want.entry);
        results_seen++;
    endtask

    // ------------------------------------------------------------------
    // image builders
    // ------------------------------------------------------------------

    task automatic push_image();
        t_image_beat beat;
        foreach (image_buf[i]) begin
            beat.word = image_buf[i];
            beat.fin  = (i == image_buf.size() - 1);
            pending_beats.push_back(beat);
        end
        image_buf.delete();
    endtask

    task automatic add_header(input logic [31:0] arch, input logic [31:0] hlen);
        image_buf.push_back(HDR_MAGIC);
        image_buf.push_back(arch);
        image_buf.push_back(hlen);
        image_buf.push_back(32'd0 - (HDR_MAGIC + arch + hlen));
    endtask

    task automatic add_random_tag(inout bit zero_seen);
        logic [15:0] kind;
        int unsigned nominal;
        int unsigned size;
        int unsigned padded;
        case ($urandom_range(0, 5))
            0, 1: begin
                kind    = KIND_ADDRESS;
                nominal = 24;
            end
            2, 3: begin
                kind    = KIND_ENTRY;
                nominal = 12;
            end
            4: begin
                kind    = 16'd0;
                nominal = 8;
            end
            default: begin
                kind    = 16'($urandom);
                nominal = 8 + 4 * $urandom_range(0, 3);
            end
        endcase
        // mostly the proper size, sometimes short, odd, oversized or zero
        case ($urandom_range(0, 11))
            0: size = 0;
            1, 2: size = $urandom_range(1, nominal + 12);
            3: size = 32'h8000_0000 | $urandom;
            default: size = nominal;
        endcase
        tag_buf.push_back({16'($urandom), kind});
        tag_buf.push_back(size);
        if (size == 0) begin
            zero_seen = 1'b1;
        end else begin
            padded = (size > 64) ? 16 : ((size + 7) & ~32'd7);
            repeat (padded / 4 - 2) tag_buf.push_back($urandom);
        end
    endtask

    task automatic add_random_image();
        int n_tags;
        int cut;
        int hit;
        bit zero_seen;
        logic [31:0] arch;
        logic [31:0] hlen;
        tag_buf.delete();
        zero_seen = 1'b0;
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 12)) image_buf.push_back($urandom);
        n_tags = $urandom_range(0, 4);
        for (int t = 0; t < n_tags && !zero_seen; t++) add_random_tag(zero_seen);
        hlen = 16 + 4 * tag_buf.size();
        case ($urandom_range(0, 9))
            0: hlen = $urandom_range(0, 16);
            1: hlen = hlen - $urandom_range(1, 12);
            2: hlen = hlen + $urandom_range(1, 24);
            3: hlen = $urandom;
            default: ;
        endcase
        arch = $urandom_range(0, 1) ? 32'd0 : $urandom;
        add_header(arch, hlen);
        // broken header: flip one bit of the magic or the checksum
        if ($urandom_range(0, 11) == 0) begin
            hit = image_buf.size() - ($urandom_range(0, 1) ? 1 : 4);
            image_buf[hit] = image_buf[hit] ^ (32'd1 << $urandom_range(0, 31));
        end
        foreach (tag_buf[i]) image_buf.push_back(tag_buf[i]);
        repeat ($urandom_range(0, 3)) image_buf.push_back($urandom);
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, image_buf.size());
            while (image_buf.size() > cut) void'(image_buf.pop_back());
        end
        push_image();
    endtask

    task automatic add_noise_image();
        repeat ($urandom_range(1, 16)) begin
            case ($urandom_range(0, 5))
                0: image_buf.push_back(32'd0);
                1: image_buf.push_back(32'hFFFF_FFFF);
                2: image_buf.push_back(HDR_MAGIC);
                default: image_buf.push_back($urandom);
            endcase
        end
        push_image();
    endtask

    // ------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------

    int gap_left = 0;
    bit send_idle_en = 1'b1;

    always @(posedge i_clk) begin
        t_image_beat beat;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                track_image_word(i_image_word, i_final_word);
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (send_idle_en && pending_beats.size() > CALM_TAIL &&
                             $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 9);
                    i_in_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    beat = pending_beats.pop_front();
                    i_in_valid   <= 1'b1;
                    i_image_word <= beat.word;
                    i_final_word <= beat.fin;
                    if ($urandom_range(0, 31) == 0) send_idle_en = !send_idle_en;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------

    int stall_left = 0;
    bit recv_stall_en = 1'b1;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) check_boot_info();
            if ($urandom_range(0, 63) == 0) recv_stall_en = !recv_stall_en;
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (recv_stall_en && pending_beats.size() > CALM_TAIL &&
                         $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 9);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // no-progress watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------

    initial begin
        int n_images;
        int plain_words;
        int words_before;
        clear_scan();

        // one word, all ones: nothing found
        image_buf.push_back(32'hFFFF_FFFF);
        push_image();
        // bare header of 16 bytes at offset 0, no tags
        add_header(32'd0, 32'd16);
        push_image();
        // header cut off by the end of the image
        add_header(32'd0, 32'd24);
        void'(image_buf.pop_back());
        push_image();
        // zero-size tag right after the header
        add_header(32'd0, 32'd24);
        image_buf.push_back({16'd0, KIND_ADDRESS});
        image_buf.push_back(32'd0);
        image_buf.push_back(32'd0);
        push_image();
        // image ends inside the tag walk
        add_header(32'd4, 32'd40);
        image_buf.push_back({16'hFFFF, KIND_ENTRY});
        image_buf.push_back(32'd12);
        image_buf.push_back(32'hFFFF_FFFF);
        push_image();

        // random images, mostly well formed
        n_images    = 0;
        plain_words = 0;
        while (plain_words < PLAIN_WORDS || n_images < MIN_IMAGES) begin
            words_before = pending_beats.size();
            if ($urandom_range(0, 4) == 0) add_noise_image();
            else add_random_image();
            plain_words += pending_beats.size() - words_before;
            n_images++;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((pending_beats.size() != 0 || i_in_valid || expected_boot_info.size() != 0)
               && stuck_cycles < STUCK_LIMIT)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (stuck_cycles < STUCK_LIMIT && mismatch_count == 0 &&
            expected_boot_info.size() == 0)
            $display("boot_header_scan_and_tag_extract_core: match");
        else
            $display("boot_header_scan_and_tag_extract_core: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/bhs_pkg.sv
design/bhs_front.sv
design/bhs_queue.sv
design/bhs_back.sv
design/boot_header_scan_and_tag_extract_core.sv
design/bhs_checker.sv
dv/tb_boot_header_scan_and_tag_extract_core.sv
